// ===== rtl/s2i_pkg.sv =====
// Shared types, constants and character helpers for the string to integer block.
// No dependencies; every other file imports this package.
package s2i_pkg;

    localparam int unsigned CH_W        = 8;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned DIGIT_W     = 5;
    localparam int unsigned SYM_REGS    = 4;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    // Register indexes of the configuration port
    localparam t_cfg_index CFG_SYMBOL_COUNT = 3'd0;
    localparam t_cfg_index CFG_SYMBOLS_0    = 3'd1;
    localparam t_cfg_index CFG_SYMBOLS_8    = 3'd2;
    localparam t_cfg_index CFG_SYMBOLS_16   = 3'd3;
    localparam t_cfg_index CFG_SYMBOLS_24   = 3'd4;

    // Reset alphabet "0123456789"
    localparam logic [COUNT_W-1:0] RST_SYMBOL_COUNT = 6'd10;
    localparam logic [VALUE_W-1:0] RST_SYMBOLS_0    = 64'h3736_3534_3332_3130;
    localparam logic [VALUE_W-1:0] RST_SYMBOLS_8    = 64'h0000_0000_0000_3938;
    localparam logic [VALUE_W-1:0] RST_SYMBOLS_16   = 64'h0;
    localparam logic [VALUE_W-1:0] RST_SYMBOLS_24   = 64'h0;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic               hit;
        logic [DIGIT_W-1:0] value;
    } t_digit;

    typedef struct packed {
        logic               zero;
        logic [VALUE_W-1:0] value;
    } t_result;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_DIGITS = 4'b0010,
        PH_KEEP   = 4'b0100,
        PH_ZERO   = 4'b1000
    } t_phase;

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic is_sign(input logic [CH_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

// ===== rtl/string_to_integer_custom_base.sv =====
// Top level of the string to integer converter with a configurable digit alphabet.
// Depends on s2i_pkg, s2i_alphabet and s2i_parse.
//
// The block parses one character per item and sustains one item per clock
// cycle unless a NUL stalls; the loop that sets this rate is the accumulator
// update, one 64 x 6 multiply and add per character, closed through the
// accumulator register. A character is held in an input register while the
// digit lookup (parallel compares against up to MAX_SYMBOLS symbols) and the
// fold run; a NUL held there loads its signed 64-bit result into the output
// register when it moves on, and the result is taken from that register.
// The output register keeps the input side moving while a result waits;
// only a NUL behind an untaken result stalls. Leading whitespace is skipped,
// one sign is taken, digits fold in as value*base+digit modulo 2^64, and the
// first non-digit settles the value (kept after '+' or '-', 0 otherwise). An
// invalid alphabet gives 0. The validity flag is registered from the alphabet
// registers after any configuration write, and configuration writes are
// always taken (ready stays high); write them only while no string is in
// flight.
module string_to_integer_custom_base
    import s2i_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave side, one character per item
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,   // [7:0] ch
    // master side, one result per finished string
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic signed [63:0]         o_m_tdata,   // [63:0] value
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [63:0]                i_cfg_data
);

    logic               r_in_valid;
    logic [CH_W-1:0]    r_ch;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_advance;
    logic               w_is_nul;
    logic [COUNT_W-1:0] w_symbol_count;
    logic               w_alpha_ok;
    t_digit             w_digit;
    t_result            w_result;

    assign o_cfg_ready = 1'b1;

    s2i_alphabet #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_alphabet (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_write    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_ch           (r_ch),
        .o_symbol_count (w_symbol_count),
        .o_alpha_ok     (w_alpha_ok),
        .o_digit        (w_digit)
    );

    s2i_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_ch           (r_ch),
        .i_digit        (w_digit),
        .i_symbol_count (w_symbol_count),
        .o_result       (w_result)
    );

    // A held character moves on unless it is a NUL facing an untaken result
    assign w_is_nul   = (r_ch == CH_NUL);
    assign w_advance  = r_in_valid && (!w_is_nul || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_ch <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_is_nul) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_is_nul) begin
            r_out <= w_result;
        end
    end

    // Drop the value to zero for a settled-zero string or a bad alphabet
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = (r_out.zero || !w_alpha_ok) ? '0 : $signed(r_out.value);

endmodule

// ===== rtl/s2i_alphabet.sv =====
// Alphabet registers, alphabet validity flag and digit lookup.
// Depends on s2i_pkg.
module s2i_alphabet
    import s2i_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_write,
    input  t_cfg_index           i_cfg_index,
    input  logic [VALUE_W-1:0]   i_cfg_data,
    input  logic [CH_W-1:0]      i_ch,
    output logic [COUNT_W-1:0]   o_symbol_count,
    output logic                 o_alpha_ok,
    output t_digit               o_digit
);

    logic [COUNT_W-1:0] r_symbol_count;
    logic [VALUE_W-1:0] r_sym_regs [SYM_REGS];
    logic               r_alpha_ok;
    logic               n_alpha_ok;

    logic [CH_W-1:0]        w_sym [MAX_SYMBOLS];
    logic [COUNT_W-1:0]     w_used;
    logic [MAX_SYMBOLS-1:0] w_used_mask;
    logic [MAX_SYMBOLS-1:0] w_hit;
    logic                   w_any_bad;

    for (genvar gi = 0; gi < MAX_SYMBOLS; gi++) begin : g_slot
        assign w_sym[gi]       = r_sym_regs[gi / 8][(gi % 8) * CH_W +: CH_W];
        assign w_used_mask[gi] = COUNT_W'(gi) < w_used;
        assign w_hit[gi]       = w_used_mask[gi] && (w_sym[gi] == i_ch);
    end

    assign w_used = (r_symbol_count > COUNT_W'(MAX_SYMBOLS)) ?
                    COUNT_W'(MAX_SYMBOLS) : r_symbol_count;

    // Lowest matching slot wins
    always_comb begin
        o_digit = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                o_digit.hit   = 1'b1;
                o_digit.value = DIGIT_W'(i);
            end
        end
    end

    // Forbidden or repeated symbols among the used slots
    always_comb begin
        w_any_bad = 1'b0;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (w_used_mask[i] && ((w_sym[i] == CH_NUL) || is_sign(w_sym[i]))) begin
                w_any_bad = 1'b1;
            end
            for (int j = 0; j < i; j++) begin
                if (w_used_mask[i] && (w_sym[j] == w_sym[i])) begin
                    w_any_bad = 1'b1;
                end
            end
        end
    end

    assign n_alpha_ok = (r_symbol_count >= COUNT_W'(2)) &&
                        (r_symbol_count <= COUNT_W'(MAX_SYMBOLS)) && !w_any_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= RST_SYMBOL_COUNT;
            r_sym_regs[0]  <= RST_SYMBOLS_0;
            r_sym_regs[1]  <= RST_SYMBOLS_8;
            r_sym_regs[2]  <= RST_SYMBOLS_16;
            r_sym_regs[3]  <= RST_SYMBOLS_24;
            r_alpha_ok     <= 1'b1;
        end else begin
            r_alpha_ok <= n_alpha_ok;
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_SYMBOL_COUNT: r_symbol_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_SYMBOLS_0:    r_sym_regs[0]  <= i_cfg_data;
                    CFG_SYMBOLS_8:    r_sym_regs[1]  <= i_cfg_data;
                    CFG_SYMBOLS_16:   r_sym_regs[2]  <= i_cfg_data;
                    CFG_SYMBOLS_24:   r_sym_regs[3]  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_symbol_count = r_symbol_count;
    assign o_alpha_ok     = r_alpha_ok;

endmodule

// ===== rtl/s2i_parse.sv =====
// Parse state (phase, sign, accumulator) and the per-character fold.
// Depends on s2i_pkg.
module s2i_parse
    import s2i_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [CH_W-1:0]    i_ch,
    input  t_digit             i_digit,
    input  logic [COUNT_W-1:0] i_symbol_count,
    output t_result            o_result
);

    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [VALUE_W-1:0] r_acc, n_acc;

    logic [VALUE_W-1:0] w_product;
    logic [VALUE_W-1:0] w_fold;

    assign w_product = r_acc * {{(VALUE_W-COUNT_W){1'b0}}, i_symbol_count};
    assign w_fold    = w_product + {{(VALUE_W-DIGIT_W){1'b0}}, i_digit.value};

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (i_ch == CH_NUL) begin
            n_phase = PH_SKIP;
            n_neg   = 1'b0;
            n_acc   = '0;
        end else begin
            unique case (r_phase) inside
                PH_SKIP: begin
                    if (is_space(i_ch)) begin
                        n_phase = PH_SKIP;
                    end else if (is_sign(i_ch)) begin
                        n_phase = PH_DIGITS;
                        n_neg   = (i_ch == CH_MINUS);
                    end else if (i_digit.hit) begin
                        n_phase = PH_DIGITS;
                        n_acc   = w_fold;
                    end else begin
                        n_phase = PH_ZERO;
                    end
                end
                PH_DIGITS: begin
                    if (i_digit.hit) begin
                        n_acc = w_fold;
                    end else if (is_sign(i_ch)) begin
                        n_phase = PH_KEEP;
                    end else begin
                        n_phase = PH_ZERO;
                    end
                end
                PH_KEEP, PH_ZERO: n_phase = r_phase;
                default:          n_phase = PH_SKIP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    assign o_result.zero  = (r_phase == PH_ZERO);
    assign o_result.value = r_neg ? ('0 - r_acc) : r_acc;

endmodule

// ===== rtl/s2i_checker.sv =====
// Port-level checks for the string to integer converter, bound to the top level.
// Depends on s2i_pkg; attaches to string_to_integer_custom_base.
module s2i_checker
    import s2i_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [7:0]             i_s_tdata,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic signed [63:0]     o_m_tdata
);

    logic w_nul_in;

    assign w_nul_in = i_s_tvalid && o_s_tready && (i_s_tdata == CH_NUL);

    // No result left over from before reset
    a_clean_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    // A new result is always caused by a NUL taken through the input register
    a_result_from_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_nul_in, 2))
        else $error("result without a terminating item");

    // A NUL meeting an empty output shows its result once past the input and output registers
    a_nul_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_nul_in && !o_m_tvalid && !$past(w_nul_in)) |=> ##1 o_m_tvalid)
        else $error("result late for terminating item");

endmodule

bind string_to_integer_custom_base s2i_checker u_s2i_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for string_to_integer_custom_base: directed strings, then random
// strings over many digit alphabets, each result checked against an in-bench parser model.
// Depends on s2i_pkg and the block's RTL only.

module tb;
    import s2i_pkg::*;

    localparam int unsigned ITEM_TARGET  = 1250;   // characters to send in all
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_PAD    = 4;      // settle time after the last awaited result
    localparam int unsigned LONG_HOLD    = 300;    // cycles the receiver holds off once
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned ALPHABET_MAX = 32;

    // Indexes past the register list; writes there must change nothing
    localparam t_cfg_index CFG_SPARE_LOW  = 3'd5;
    localparam t_cfg_index CFG_SPARE_HIGH = 3'd7;

    typedef enum {ROW_WRITE, ROW_TEXT} t_row_kind;

    typedef enum {
        SET_DECIMAL, SET_HEX, SET_BINARY, SET_WIDEST, SET_RANDOM, SET_BLANKS, SET_BROKEN
    } t_alphabet_kind;

    typedef struct {
        t_row_kind   kind;
        t_cfg_index  index;
        logic [63:0] data;
        string       text;
        bit          typed;    // use want instead of the parser model
        logic [63:0] want;
    } t_plan_row;

    // ---------------------------------------------------------------- DUT ports
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_s_tvalid  = 1'b0;
    logic               o_s_tready;
    logic [7:0]         i_s_tdata   = '0;        // [7:0] ch
    logic               o_m_tvalid;
    logic               i_m_tready  = 1'b0;
    logic signed [63:0] o_m_tdata;               // [63:0] value
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    t_cfg_index         i_cfg_index = CFG_SYMBOL_COUNT;
    logic [63:0]        i_cfg_data  = '0;

    string_to_integer_custom_base #(
        .MAX_SYMBOLS (ALPHABET_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------- parser model state
    logic [COUNT_W-1:0] radix;
    logic [63:0]        glyph_word [SYM_REGS];
    t_phase             scan_phase;
    bit                 minus_seen;
    logic [63:0]        running_value;

    // Values of finished strings not yet seen on the master side, oldest first
    logic [63:0] awaited_values [$];

    // Stimulus scratch: the characters of the next string, and an alphabet being built
    logic [7:0]         draft [$];
    logic [7:0]         glyph_plan [ALPHABET_MAX];
    logic [COUNT_W-1:0] plan_count;

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned chars_sent = 0;
    int unsigned strings_sent = 0;
    int unsigned writes_done = 0;
    int unsigned hold_asks = 0;
    int unsigned holds_granted = 0;
    bit          calm = 1'b0;     // no idling on either side near the end
    bit          paced = 1'b0;    // sender inserts gaps within the current string
    logic [63:0] want_value;

    // ---------------------------------------------------------- parser model
    function automatic logic [7:0] glyph_at(input int unsigned k);
        return glyph_word[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function automatic int unsigned glyphs_in_use();
        return (radix > ALPHABET_MAX) ? ALPHABET_MAX : int'(radix);
    endfunction

    // The alphabet counts only with at least two used symbols, none NUL or a sign,
    // all distinct.
    function automatic bit alphabet_ok();
        logic [7:0] g;
        if (radix < 2 || radix > ALPHABET_MAX) return 1'b0;
        for (int unsigned k = 0; k < glyphs_in_use(); k++) begin
            g = glyph_at(k);
            if (g == CH_NUL || g == CH_PLUS || g == CH_MINUS) return 1'b0;
            for (int unsigned j = 0; j < k; j++)
                if (glyph_at(j) == g) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Lowest matching index wins, even with duplicates
    function automatic int digit_value(input logic [7:0] c);
        for (int unsigned k = 0; k < glyphs_in_use(); k++)
            if (glyph_at(k) == c) return int'(k);
        return -1;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        case (c) inside
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Advance the parser by one character; true when it finishes a string.
    function automatic bit parse_char(input logic [7:0] c, output logic [63:0] value);
        int d;
        value = '0;
        if (c == CH_NUL) begin
            if (alphabet_ok() && scan_phase != PH_ZERO)
                value = minus_seen ? -running_value : running_value;
            scan_phase    = PH_SKIP;
            minus_seen    = 1'b0;
            running_value = '0;
            return 1'b1;
        end
        // Blanks are skipped here even when they are also digits
        if (scan_phase == PH_SKIP) begin
            if (is_blank(c)) return 1'b0;
            scan_phase = PH_DIGITS;
            if (c == CH_PLUS || c == CH_MINUS) begin
                minus_seen = (c == CH_MINUS);
                return 1'b0;
            end
        end
        if (scan_phase == PH_DIGITS) begin
            d = digit_value(c);
            if (d >= 0)
                running_value = running_value * 64'(radix) + 64'(d);
            else if (c == CH_PLUS || c == CH_MINUS)
                scan_phase = PH_KEEP;
            else
                scan_phase = PH_ZERO;
        end
        return 1'b0;
    endfunction

    function automatic void store_register(input t_cfg_index idx, input logic [63:0] data);
        case (idx)
            CFG_SYMBOL_COUNT: radix         = data[COUNT_W-1:0];
            CFG_SYMBOLS_0:    glyph_word[0] = data;
            CFG_SYMBOLS_8:    glyph_word[1] = data;
            CFG_SYMBOLS_16:   glyph_word[2] = data;
            CFG_SYMBOLS_24:   glyph_word[3] = data;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------- stimulus helpers
    function automatic logic [7:0] noise_char();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // Fill the first n slots with distinct symbols that make a valid alphabet;
    // leave any byte in the slots past n.
    function automatic void draw_distinct(input int unsigned n, input bit with_blanks);
        logic [7:0] c;
        bit clash;
        for (int unsigned k = 0; k < ALPHABET_MAX; k++)
            glyph_plan[k] = 8'($urandom_range(0, 255));
        for (int unsigned k = 0; k < n; k++) begin
            do begin
                c = (with_blanks && $urandom_range(0, 2) == 0) ? blank_char() : noise_char();
                clash = (c == CH_PLUS || c == CH_MINUS);
                for (int unsigned j = 0; j < k; j++)
                    if (glyph_plan[j] == c) clash = 1'b1;
            end while (clash);
            glyph_plan[k] = c;
        end
    endfunction

    // Offer one character and hold it until taken; predict at the handshake.
    task automatic feed_char(input logic [7:0] c, input bit typed, input logic [63:0] typed_value);
        logic [63:0] predicted;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        do @(posedge i_clk); while (!o_s_tready);
        chars_sent++;
        if (parse_char(c, predicted))
            awaited_values.push_back(typed ? typed_value : predicted);
        // Drop valid for a burst now and then; the caller raises it with the next item
        if (!calm && paced && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic feed_draft(input bit typed, input logic [63:0] typed_value);
        foreach (draft[k]) feed_char(draft[k], 1'b0, '0);
        feed_char(CH_NUL, typed, typed_value);
        strings_sent++;
    endtask

    // Stop offering, wait out every awaited result, then let the pipe empty.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (awaited_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Registers change only with the block idle
    task automatic write_register(input t_cfg_index idx, input logic [63:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        store_register(idx, data);
        writes_done++;
    endtask

    task automatic load_alphabet(input t_alphabet_kind kind);
        logic [63:0] word;
        int unsigned n, j;
        n = $urandom_range(2, ALPHABET_MAX);
        case (kind)
            SET_DECIMAL: begin
                plan_count = 10;
                draw_distinct(0, 1'b0);
                for (int unsigned k = 0; k < 10; k++) glyph_plan[k] = "0" + 8'(k);
            end
            SET_HEX: begin
                plan_count = 16;
                draw_distinct(0, 1'b0);
                for (int unsigned k = 0; k < 10; k++) glyph_plan[k] = "0" + 8'(k);
                for (int unsigned k = 10; k < 16; k++) glyph_plan[k] = "a" + 8'(k - 10);
            end
            SET_BINARY: begin
                plan_count = 2;
                draw_distinct(2, 1'b0);
            end
            SET_WIDEST: begin
                plan_count = ALPHABET_MAX;
                draw_distinct(ALPHABET_MAX, 1'b0);
            end
            SET_RANDOM: begin
                plan_count = COUNT_W'(n);
                draw_distinct(n, 1'b0);
            end
            SET_BLANKS: begin
                n = $urandom_range(3, 12);
                plan_count = COUNT_W'(n);
                draw_distinct(n, 1'b1);
            end
            default: begin
                // Start valid, then break it one way or another
                plan_count = COUNT_W'(n);
                draw_distinct(n, 1'b0);
                case ($urandom_range(0, 5))
                    0: plan_count = COUNT_W'($urandom_range(0, 1));
                    1: plan_count = COUNT_W'($urandom_range(33, 63));
                    2: begin
                        j = $urandom_range(1, n - 1);
                        glyph_plan[j] = glyph_plan[$urandom_range(0, j - 1)];
                    end
                    3: glyph_plan[$urandom_range(0, n - 1)] =
                           $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                    4: glyph_plan[$urandom_range(0, n - 1)] = CH_NUL;
                    default: begin
                        plan_count = '1;
                        for (int unsigned k = 0; k < ALPHABET_MAX; k++) glyph_plan[k] = 8'hFF;
                    end
                endcase
            end
        endcase
        // Junk above the count field must be masked off
        write_register(CFG_SYMBOL_COUNT, {32'($urandom), 26'($urandom), plan_count});
        for (int unsigned w = 0; w < SYM_REGS; w++) begin
            for (int unsigned k = 0; k < 8; k++) word[k * 8 +: 8] = glyph_plan[w * 8 + k];
            write_register(t_cfg_index'(CFG_SYMBOLS_0 + w), word);
        end
        if ($urandom_range(0, 2) == 0)
            write_register($urandom_range(0, 1) ? CFG_SPARE_LOW : CFG_SPARE_HIGH,
                           {$urandom, $urandom});
    endtask

    // Mostly well-formed numbers in the current alphabet, with signs, blanks and
    // stray tails; the rest empty, sign-only or noise.
    task automatic compose_string();
        int unsigned used, shape;
        draft.delete();
        used  = glyphs_in_use();
        shape = $urandom_range(0, 9);
        if (shape <= 6 && used > 0) begin
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) draft.push_back(blank_char());
            case ($urandom_range(0, 2))
                1: draft.push_back(CH_PLUS);
                2: draft.push_back(CH_MINUS);
                default: ;
            endcase
            // Long runs push the accumulator through its wrap
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6))
                draft.push_back(glyph_at($urandom_range(0, used - 1)));
            case ($urandom_range(0, 6))
                0: begin
                    draft.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    draft.push_back(glyph_at($urandom_range(0, used - 1)));
                end
                1: begin
                    draft.push_back(noise_char());
                    draft.push_back(glyph_at($urandom_range(0, used - 1)));
                end
                default: ;
            endcase
        end else if (shape == 7) begin
            if ($urandom_range(0, 1) == 1)
                draft.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        end else begin
            repeat ($urandom_range(1, 6)) draft.push_back(noise_char());
        end
    endtask

    // ------------------------------------------------------------------- clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------- cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("cycle limit hit with %0d results outstanding", awaited_values.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ---------------------------------------------------------------- receiver
    // Random ready bursts, free-running stretches, and one long hold-off on request.
    initial begin
        int unsigned idle_left, free_left, hold_left;
        idle_left = 0;
        free_left = 0;
        hold_left = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (holds_granted != hold_asks) begin
                holds_granted++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                i_m_tready <= 1'b0;
            end else if (calm || free_left > 0) begin
                if (free_left > 0) free_left--;
                i_m_tready <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(1, 19) - 1;
                i_m_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 3) == 0) free_left = $urandom_range(10, 60);
                i_m_tready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------- result check
    // Sample at the edge: the DUT's outputs still hold their pre-edge values here.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (awaited_values.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("cycle %0d: result %0d with none awaited", cycle_count, o_m_tdata);
            end else begin
                want_value = awaited_values.pop_front();
                if (o_m_tdata !== want_value) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("cycle %0d: value expected %0d (0x%h), got %0d (0x%h)",
                                 cycle_count, $signed(want_value), want_value,
                                 o_m_tdata, o_m_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------ main sequence
    initial begin
        t_plan_row   plan [$];
        int unsigned phase_idx, budget;

        // Model starts from the reset alphabet "0123456789"
        radix         = RST_SYMBOL_COUNT;
        glyph_word[0] = RST_SYMBOLS_0;
        glyph_word[1] = RST_SYMBOLS_8;
        glyph_word[2] = RST_SYMBOLS_16;
        glyph_word[3] = RST_SYMBOLS_24;
        scan_phase    = PH_SKIP;
        minus_seen    = 1'b0;
        running_value = '0;

        // Directed rows. Text rows end with an implied NUL; typed rows carry the value.
        // Decimal after reset: empty, blanks, signs, settling, wrap, extremes of ch
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "", 1'b1, 64'd0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "0", 1'b1, 64'd0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, " \t\n\013\014\r-42", 1'b1, -64'sd42});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "+17", 1'b1, 64'd17});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "-", 1'b1, 64'd0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "--5", 1'b1, 64'd0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "123+99", 1'b1, 64'd123});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "-123-", 1'b1, -64'sd123});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "123x", 1'b1, 64'd0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "12 3", 1'b1, 64'd0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "\377", 1'b1, 64'd0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "18446744073709551615", 1'b1, '1});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "-9223372036854775808", 1'b1,
                         64'h8000_0000_0000_0000});
        // Lowercase hex
        plan.push_back('{ROW_WRITE, CFG_SYMBOL_COUNT, 64'd16, "", 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SYMBOLS_8, 64'h6665_6463_6261_3938, "", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "ff", 1'b1, 64'd255});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "-10", 1'b1, -64'sd16});
        // Base 2 over " " and "x": leading blanks skip, inner blanks are zeros
        plan.push_back('{ROW_WRITE, CFG_SYMBOL_COUNT, 64'd2, "", 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SYMBOLS_0, 64'h7820, "", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "  x x", 1'b1, 64'd5});
        // Count out of range on both sides
        plan.push_back('{ROW_WRITE, CFG_SYMBOL_COUNT, 64'd63, "", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "x", 1'b1, 64'd0});
        plan.push_back('{ROW_WRITE, CFG_SYMBOL_COUNT, 64'd1, "", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, " x", 1'b1, 64'd0});
        // All 32 symbols "0-9A-V"
        plan.push_back('{ROW_WRITE, CFG_SYMBOL_COUNT, 64'd32, "", 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SYMBOLS_0, RST_SYMBOLS_0, "", 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SYMBOLS_8, 64'h4645_4443_4241_3938, "", 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SYMBOLS_16, 64'h4E4D_4C4B_4A49_4847, "", 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SYMBOLS_24, 64'h5655_5453_5251_504F, "", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "V", 1'b1, 64'd31});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "10", 1'b1, 64'd32});
        // Duplicate symbol, then a sign among the symbols
        plan.push_back('{ROW_WRITE, CFG_SYMBOLS_24, 64'h5655_5453_5251_5030, "", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "1", 1'b1, 64'd0});
        plan.push_back('{ROW_WRITE, CFG_SYMBOLS_24, 64'h5655_5453_5251_502B, "", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "1", 1'b1, 64'd0});
        // Writes past the register list leave the alphabet alone
        plan.push_back('{ROW_WRITE, CFG_SYMBOLS_24, 64'h5655_5453_5251_504F, "", 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SPARE_LOW, '1, "", 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SPARE_HIGH, '1, "", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "-V0", 1'b1, -64'sd992});
        // Eleven symbols reach a NUL slot of the reset alphabet
        plan.push_back('{ROW_WRITE, CFG_SYMBOL_COUNT, 64'd11, "", 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SYMBOLS_8, RST_SYMBOLS_8, "", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "5", 1'b1, 64'd0});
        // Back to decimal, checked by the model
        plan.push_back('{ROW_WRITE, CFG_SYMBOL_COUNT, 64'(RST_SYMBOL_COUNT), "", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "  +0099", 1'b0, '0});
        plan.push_back('{ROW_TEXT, CFG_SYMBOL_COUNT, '0, "7\t", 1'b0, '0});

        // Hold reset, then release it for good
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE) begin
                write_register(plan[r].index, plan[r].data);
            end else begin
                draft.delete();
                for (int k = 0; k < plan[r].text.len(); k++) draft.push_back(plan[r].text[k]);
                paced = $urandom_range(0, 1);
                feed_draft(plan[r].typed, plan[r].want);
            end
        end

        // Random phases: new alphabet per phase, then a run of strings in it.
        // Phase three asks the receiver for its long hold so the block backs up.
        phase_idx = 0;
        while (chars_sent < ITEM_TARGET) begin
            load_alphabet(t_alphabet_kind'(phase_idx % 7));
            if (phase_idx == 3) hold_asks++;
            budget = chars_sent + $urandom_range(80, 140);
            while (chars_sent < budget && chars_sent < ITEM_TARGET) begin
                calm  = (chars_sent >= ITEM_TARGET * 85 / 100);
                paced = !calm && ($urandom_range(0, 1) == 1);
                compose_string();
                feed_draft(1'b0, '0);
            end
            phase_idx++;
        end

        // Wait for every result, give stray outputs time to show, then report
        drain();
        repeat (DRAIN_PAD * 4) @(posedge i_clk);
        $display("run covered %0d strings (%0d characters) and %0d results over %0d alphabets,",
                 strings_sent, chars_sent, results_seen, phase_idx + 1);
        $display("with %0d register writes, %0d mismatches", writes_done, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/s2i_pkg.sv
rtl/s2i_alphabet.sv
rtl/s2i_parse.sv
rtl/string_to_integer_custom_base.sv
rtl/s2i_checker.sv
tb/tb.sv
